// ===== design/gcb_pkg.sv =====
// Shared types, constants and helper functions for the tone-curve generator.
// Used by every design file; it depends on nothing else.
package gcb_pkg;

    // Field and register widths.
    localparam int IDX_BITS       = 12;
    localparam int VAL_BITS       = 16;
    localparam int TSIZE_BITS     = 13;
    localparam int GAMMA_BITS     = 10;
    localparam int LOG_BITS       = 20;
    localparam int FRAC_BITS      = 16;
    localparam int LOG_STEPS      = 16;
    localparam int DIV_BITS       = 27;
    localparam int POW_STEPS      = 16;
    localparam int POW_BITS       = 33;
    localparam int PADDR_BITS     = 5;
    localparam int DATA_BITS      = 32;
    localparam int MAX_TABLE_SIZE = 4096;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_BRIGHTNESS = 3'd0;
    localparam logic [2:0] REG_CONTRAST   = 3'd1;
    localparam logic [2:0] REG_GAMMA      = 3'd2;
    localparam logic [2:0] REG_MAX_VALUE  = 3'd3;
    localparam logic [2:0] REG_TABLE_SIZE = 3'd4;

    // Sideband that travels with every pipeline stage.
    typedef struct packed {
        logic vld;
        logic err;
        logic zero;
    } side_t;

    // Coefficients derived from the configuration registers.
    typedef struct packed {
        logic [23:0]        slope;
        logic signed [35:0] offset;
        logic [19:0]        log2n;
        logic [15:0]        maxv;
        logic [9:0]         gdiv;
        logic [12:0]        nsize;
    } coef_t;

    // Position of the most significant set bit; zero for zero and one.
    function automatic logic [3:0] msb_pos(input logic [12:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 1; i < 13; i++) begin
            if (v[i]) begin
                n = 4'(i);
            end
        end
        return n;
    endfunction

    // Mantissa of v normalised to Q1.31.
    function automatic logic [31:0] log_init(input logic [12:0] v);
        logic [3:0]  n;
        logic [31:0] w;
        n = msb_pos(v);
        w = {19'd0, v};
        return w << (5'd31 - {1'b0, n});
    endfunction

    // One squaring step of the log2 fraction: {fraction bit, new mantissa}.
    function automatic logic [32:0] log_step(input logic [31:0] m);
        logic [63:0] sq;
        logic [32:0] s;
        sq = {32'd0, m} * {32'd0, m};
        s  = sq[63:31];
        return s[32] ? {1'b1, s[32:1]} : {1'b0, s[31:0]};
    endfunction

    // Integer square root, evaluated at elaboration only.
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] rem;
        r   = 64'd0;
        rem = v;
        b   = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Successive square roots of one half in Q0.32.
    function automatic logic [15:0][31:0] root_table();
        logic [15:0][31:0] t;
        logic [63:0]       c;
        c    = isqrt64(64'h8000_0000_0000_0000);
        t[0] = c[31:0];
        for (int k = 1; k < 16; k++) begin
            c    = isqrt64({c[31:0], 32'd0});
            t[k] = c[31:0];
        end
        return t;
    endfunction

    localparam logic [15:0][31:0] ROOT_C = root_table();

endpackage

// ===== design/gcb_index_if.sv =====
// Index channel: one table index per beat.
// Depends on gcb_pkg for the field width.
interface gcb_index_if;
    logic                         valid;
    logic                         ready;
    logic [gcb_pkg::IDX_BITS-1:0] entry_index;

    modport source (output valid, output entry_index, input ready);
    modport sink   (input valid, input entry_index, output ready);
endinterface

// ===== design/gcb_entry_if.sv =====
// Entry channel: one curve value and its error flag per beat.
// Depends on gcb_pkg for the field width.
interface gcb_entry_if;
    logic                         valid;
    logic                         ready;
    logic [gcb_pkg::VAL_BITS-1:0] entry_value;
    logic                         index_error;

    modport source (output valid, output entry_value, output index_error, input ready);
    modport sink   (input valid, input entry_value, input index_error, output ready);
endinterface

// ===== design/gcb_coef.sv =====
// Configuration registers with their APB-style port, and a sequencer that
// derives slope, offset and log2 of the table size. Depends on gcb_pkg.
module gcb_coef (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gcb_pkg::PADDR_BITS-1:0] paddr,
    input  logic [gcb_pkg::DATA_BITS-1:0]  pwdata,
    output logic [gcb_pkg::DATA_BITS-1:0]  prdata,
    output gcb_pkg::coef_t                 coef,
    output logic                           busy
);

    localparam logic [5:0]  LAST_STEP   = 6'd23;
    localparam logic [5:0]  SLOPE_STEPS = 6'd24;
    localparam logic [5:0]  LOG_STEPS   = 6'd16;
    localparam logic [23:0] SLOPE_NUM   = 24'd13107200;
    localparam logic [23:0] ONE_Q16     = 24'd65536;
    localparam logic [23:0] RECIP_100   = 24'd10737419;
    localparam logic [21:0] RECIP_25    = 22'd2684355;
    localparam logic [23:0] PCT_DIV     = 24'd100;

    logic [7:0]  bright_reg;
    logic [7:0]  contrast_reg;
    logic [9:0]  gamma_reg;
    logic [15:0] maxv_reg;
    logic [12:0] tsize_reg;

    logic        load_reg, run_reg, done_reg;
    logic        load_next, run_next, done_next;
    logic [5:0]  cnt_reg, cnt_next;

    logic [23:0] sw_reg, sw_next;
    logic [7:0]  srem_reg, srem_next;
    logic [31:0] lm_reg, lm_next;
    logic [3:0]  ln_reg, ln_next;
    logic [15:0] lf_reg, lf_next;

    logic [23:0] bprod_reg;
    logic [16:0] bq_reg;
    logic [15:0] bfrac_reg;

    logic [23:0]        slope_reg;
    logic signed [35:0] offset_reg;
    logic [19:0]        log2n_reg;

    logic               wr;
    logic [2:0]         widx;
    logic signed [8:0]  cl9;
    logic signed [8:0]  d9;
    logic [7:0]         dv;
    logic               bneg;
    logic [7:0]         bmag;
    logic [23:0]        bprod;
    logic [12:0]        nsize;
    logic [8:0]         st;
    logic               sge;
    logic [32:0]        lstep;
    logic [47:0]        bq_prod;
    logic [23:0]        brem_w;
    logic [28:0]        bf_prod;
    logic signed [35:0] qs;
    logic signed [35:0] half36;

    assign wr   = psel & penable & pwrite;
    assign widx = paddr[4:2];

    // Register read-back.
    always_comb
    begin
        case (widx)
            gcb_pkg::REG_BRIGHTNESS: prdata = {24'd0, bright_reg};
            gcb_pkg::REG_CONTRAST:   prdata = {24'd0, contrast_reg};
            gcb_pkg::REG_GAMMA:      prdata = {22'd0, gamma_reg};
            gcb_pkg::REG_MAX_VALUE:  prdata = {16'd0, maxv_reg};
            gcb_pkg::REG_TABLE_SIZE: prdata = {19'd0, tsize_reg};
            default:                 prdata = '0;
        endcase
    end

    // Register writes; any write restarts the coefficient sequence.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_reg   <= 8'd0;
            contrast_reg <= 8'd0;
            gamma_reg    <= 10'd100;
            maxv_reg     <= 16'd255;
            tsize_reg    <= 13'd256;
        end
        else if (wr)
        begin
            case (widx)
                gcb_pkg::REG_BRIGHTNESS: bright_reg   <= pwdata[7:0];
                gcb_pkg::REG_CONTRAST:   contrast_reg <= pwdata[7:0];
                gcb_pkg::REG_GAMMA:      gamma_reg    <= pwdata[9:0];
                gcb_pkg::REG_MAX_VALUE:  maxv_reg     <= pwdata[15:0];
                gcb_pkg::REG_TABLE_SIZE: tsize_reg    <= pwdata[12:0];
                default:                 ;
            endcase
        end
    end

    // Operands taken straight from the registers.
    always_comb
    begin
        cl9 = {contrast_reg[7], contrast_reg};
        if (cl9 < -9'sd100)
        begin
            cl9 = -9'sd100;
        end
        if (cl9 > 9'sd99)
        begin
            cl9 = 9'sd99;
        end
        d9    = 9'sd100 - cl9;
        dv    = d9[7:0];
        bneg  = bright_reg[7];
        bmag  = bneg ? 8'(~bright_reg + 8'd1) : bright_reg;
        bprod = {16'd0, bmag} * {8'd0, maxv_reg};
        nsize = (tsize_reg > 13'(gcb_pkg::MAX_TABLE_SIZE))
              ? 13'(gcb_pkg::MAX_TABLE_SIZE) : tsize_reg;
    end

    // Brightness magnitude times max_value times 65536 over 100: the quotient
    // and remainder by 100 come from a reciprocal multiply, then the remainder's
    // share of 65536/100 from a second one. Settles well within the sequence.
    always_comb
    begin
        bq_prod = {24'd0, bprod_reg} * {24'd0, RECIP_100};
        brem_w  = bprod_reg - 24'({7'd0, bq_reg} * PCT_DIV);
        bf_prod = {22'd0, brem_w[6:0]} * {7'd0, RECIP_25};
    end

    always_ff @(posedge clk)
    begin
        bprod_reg <= bprod;
        bq_reg    <= bq_prod[46:30];
        bfrac_reg <= bf_prod[27:12];
    end

    // Sequencer: one restoring step of the slope divider and one log2
    // squaring per cycle.
    always_comb
    begin
        load_next = load_reg | wr;
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sw_next   = sw_reg;
        srem_next = srem_reg;
        lm_next   = lm_reg;
        ln_next   = ln_reg;
        lf_next   = lf_reg;

        st    = {srem_reg, sw_reg[23]};
        sge   = st >= {1'b0, dv};
        lstep = gcb_pkg::log_step(lm_reg);

        if (load_reg)
        begin
            load_next = wr;
            run_next  = 1'b1;
            cnt_next  = 6'd0;
            sw_next   = SLOPE_NUM;
            srem_next = 8'd0;
            lm_next   = gcb_pkg::log_init(nsize);
            ln_next   = gcb_pkg::msb_pos(nsize);
            lf_next   = 16'd0;
        end
        else if (run_reg)
        begin
            if (cnt_reg < SLOPE_STEPS)
            begin
                srem_next = sge ? 8'(st - {1'b0, dv}) : st[7:0];
                sw_next   = {sw_reg[22:0], sge};
            end
            if (cnt_reg < LOG_STEPS)
            begin
                lm_next = lstep[31:0];
                lf_next = {lf_reg[14:0], lstep[32]};
            end
            cnt_next  = cnt_reg + 6'd1;
            if (cnt_reg == LAST_STEP)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg <= 1'b1;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            load_reg <= load_next;
            run_reg  <= run_next & ~wr;
            done_reg <= done_next & ~wr;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sw_reg   <= sw_next;
        srem_reg <= srem_next;
        lm_reg   <= lm_next;
        ln_reg   <= ln_next;
        lf_reg   <= lf_next;
    end

    // Final coefficients, latched once the sequence completes.
    assign qs     = $signed({3'd0, bq_reg, bfrac_reg});
    assign half36 = $signed({5'd0, maxv_reg, 15'd0});

    always_ff @(posedge clk)
    begin
        if (done_reg)
        begin
            slope_reg  <= sw_reg - ONE_Q16;
            offset_reg <= half36 + (bneg ? -qs : qs) + 36'sd32768;
            log2n_reg  <= {ln_reg, lf_reg};
        end
    end

    assign busy = load_reg | run_reg | done_reg;

    assign coef.slope  = slope_reg;
    assign coef.offset = offset_reg;
    assign coef.log2n  = log2n_reg;
    assign coef.maxv   = maxv_reg;
    assign coef.gdiv   = (gamma_reg == 10'd0) ? 10'd1 : gamma_reg;
    assign coef.nsize  = nsize;

endmodule

// ===== design/gcb_log_pipe.sv =====
// Log2 of the table index: normalise stage and sixteen squaring stages.
// Depends on gcb_pkg.
module gcb_log_pipe (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_vld,
    input  logic [gcb_pkg::IDX_BITS-1:0] idx,
    input  logic [12:0]                  nsize,
    output gcb_pkg::side_t               out_side,
    output logic [gcb_pkg::LOG_BITS-1:0] log2i
);

    localparam int S = gcb_pkg::LOG_STEPS;

    logic [31:0]    m_reg [0:S];
    logic [31:0]    m_next [0:S];
    logic [3:0]     n_reg [0:S];
    logic [3:0]     n_next [0:S];
    logic [15:0]    f_reg [0:S];
    logic [15:0]    f_next [0:S];
    gcb_pkg::side_t side_reg [0:S];
    gcb_pkg::side_t side_next [0:S];
    logic [32:0]    step_w [0:S-1];

    // Entry stage, then one squaring per stage.
    always_comb
    begin
        m_next[0]    = gcb_pkg::log_init({1'b0, idx});
        n_next[0]    = gcb_pkg::msb_pos({1'b0, idx});
        f_next[0]    = 16'd0;
        side_next[0] = gcb_pkg::side_t'{vld: in_vld, err: ({1'b0, idx} >= nsize),
                                        zero: (idx == '0)};
        for (int k = 0; k < S; k++)
        begin
            step_w[k]      = gcb_pkg::log_step(m_reg[k]);
            m_next[k+1]    = step_w[k][31:0];
            f_next[k+1]    = {f_reg[k][14:0], step_w[k][32]};
            n_next[k+1]    = n_reg[k];
            side_next[k+1] = side_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= S; k++)
            begin
                side_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            side_reg <= side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_reg <= m_next;
            n_reg <= n_next;
            f_reg <= f_next;
        end
    end

    assign out_side = side_reg[S];
    assign log2i    = {n_reg[S], f_reg[S]};

endmodule

// ===== design/gcb_div_pipe.sv =====
// Curve exponent: log ratio times 100, divided by gamma one quotient bit per
// stage (restoring). Depends on gcb_pkg.
module gcb_div_pipe (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  gcb_pkg::side_t                 in_side,
    input  logic [gcb_pkg::LOG_BITS-1:0]   log2i,
    input  logic [gcb_pkg::LOG_BITS-1:0]   log2n,
    input  logic [gcb_pkg::GAMMA_BITS-1:0] gdiv,
    output gcb_pkg::side_t                 out_side,
    output logic [gcb_pkg::DIV_BITS-1:0]   expo
);

    localparam int S = gcb_pkg::DIV_BITS;
    localparam int G = gcb_pkg::GAMMA_BITS;

    logic [S-1:0]   w_reg [0:S];
    logic [S-1:0]   w_next [0:S];
    logic [G-1:0]   r_reg [0:S];
    logic [G-1:0]   r_next [0:S];
    gcb_pkg::side_t side_reg [0:S];
    gcb_pkg::side_t side_next [0:S];
    logic [G:0]     t_w [0:S-1];
    logic           ge_w [0:S-1];
    logic [gcb_pkg::LOG_BITS-1:0] diff;

    always_comb
    begin
        diff         = log2n - log2i;
        w_next[0]    = {7'd0, diff} * 27'd100;
        r_next[0]    = '0;
        side_next[0] = in_side;
        for (int k = 0; k < S; k++)
        begin
            t_w[k]         = {r_reg[k], w_reg[k][S-1]};
            ge_w[k]        = t_w[k] >= {1'b0, gdiv};
            r_next[k+1]    = ge_w[k] ? G'(t_w[k] - {1'b0, gdiv}) : t_w[k][G-1:0];
            w_next[k+1]    = {w_reg[k][S-2:0], ge_w[k]};
            side_next[k+1] = side_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= S; k++)
            begin
                side_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            side_reg <= side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_reg <= w_next;
            r_reg <= r_next;
        end
    end

    assign out_side = side_reg[S];
    assign expo     = w_reg[S];

endmodule

// ===== design/gcb_pow_pipe.sv =====
// 2^-M: one root multiply per fraction bit, then the whole-part shift.
// Depends on gcb_pkg for the root constants.
module gcb_pow_pipe (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  gcb_pkg::side_t               in_side,
    input  logic [gcb_pkg::DIV_BITS-1:0] expo,
    output gcb_pkg::side_t               out_side,
    output logic [gcb_pkg::POW_BITS-1:0] pw
);

    localparam int S = gcb_pkg::POW_STEPS;
    localparam int P = gcb_pkg::POW_BITS;
    localparam logic [P-1:0] ONE_Q32 = {1'b1, {(P-1){1'b0}}};

    logic [P-1:0]   p_reg [0:S-1];
    logic [P-1:0]   p_next [0:S-1];
    logic [15:0]    fr_reg [0:S-1];
    logic [15:0]    fr_next [0:S-1];
    logic [10:0]    wh_reg [0:S-1];
    logic [10:0]    wh_next [0:S-1];
    gcb_pkg::side_t side_reg [0:S-1];
    gcb_pkg::side_t side_next [0:S-1];
    logic [64:0]    pr_w [1:S-1];
    logic [P-1:0]   pw_reg, pw_next;
    gcb_pkg::side_t oside_reg;

    always_comb
    begin
        // First fraction bit: 1.0 times the root is the root itself.
        p_next[0]    = expo[15] ? {1'b0, gcb_pkg::ROOT_C[0]} : ONE_Q32;
        fr_next[0]   = {expo[14:0], 1'b0};
        wh_next[0]   = expo[26:16];
        side_next[0] = in_side;
        for (int k = 1; k < S; k++)
        begin
            pr_w[k]      = {32'd0, p_reg[k-1]} * {33'd0, gcb_pkg::ROOT_C[k]};
            p_next[k]    = fr_reg[k-1][15] ? pr_w[k][64:32] : p_reg[k-1];
            fr_next[k]   = {fr_reg[k-1][14:0], 1'b0};
            wh_next[k]   = wh_reg[k-1];
            side_next[k] = side_reg[k-1];
        end
        // Whole part of the exponent; index zero or a whole part of 32 or more gives zero.
        if (side_reg[S-1].zero || (wh_reg[S-1][10:5] != 6'd0))
        begin
            pw_next = '0;
        end
        else
        begin
            pw_next = p_reg[S-1] >> wh_reg[S-1][4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < S; k++)
            begin
                side_reg[k] <= '0;
            end
            oside_reg <= '0;
        end
        else if (adv)
        begin
            side_reg  <= side_next;
            oside_reg <= side_reg[S-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg  <= p_next;
            fr_reg <= fr_next;
            wh_reg <= wh_next;
            pw_reg <= pw_next;
        end
    end

    assign out_side = oside_reg;
    assign pw       = pw_reg;

endmodule

// ===== design/gcb_curve.sv =====
// Scaling to max_value, contrast about mid-scale, brightness and clamp.
// Depends on gcb_pkg.
module gcb_curve (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  gcb_pkg::side_t               in_side,
    input  logic [gcb_pkg::POW_BITS-1:0] pw,
    input  gcb_pkg::coef_t               coef,
    output gcb_pkg::side_t               out_side,
    output logic [gcb_pkg::VAL_BITS-1:0] value
);

    logic [32:0]        x_reg;
    logic [48:0]        pxm;
    logic signed [33:0] dx;
    logic signed [58:0] sl59;
    logic signed [58:0] dx59;
    logic signed [58:0] prod_reg, prod_next;
    logic signed [58:0] prod_sh;
    logic signed [43:0] y;
    logic signed [43:0] top44;
    gcb_pkg::side_t     xside_reg, yside_reg;

    // Scale to max_value, then the contrast product.
    always_comb
    begin
        pxm       = {16'd0, pw} * {33'd0, coef.maxv};
        dx        = $signed({1'b0, x_reg}) - $signed({3'd0, coef.maxv, 15'd0});
        sl59      = $signed({35'd0, coef.slope});
        dx59      = {{25{dx[33]}}, dx};
        prod_next = sl59 * dx59;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xside_reg <= '0;
            yside_reg <= '0;
        end
        else if (adv)
        begin
            xside_reg <= in_side;
            yside_reg <= xside_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg    <= pxm[48:16];
            prod_reg <= prod_next;
        end
    end

    // Offset and clamp to [0, max_value]; an out-of-table index gives zero.
    always_comb
    begin
        prod_sh = prod_reg >>> 16;
        y       = 44'(prod_sh) + {{8{coef.offset[35]}}, coef.offset};
        top44   = $signed({12'd0, coef.maxv, 16'd0});
        if (yside_reg.err)
        begin
            value = '0;
        end
        else if (y > top44)
        begin
            value = coef.maxv;
        end
        else if (y[43])
        begin
            value = '0;
        end
        else
        begin
            value = y[31:16];
        end
    end

    assign out_side = yside_reg;

endmodule

// ===== design/gamma_contrast_brightness_curve_unit.sv =====
// Tone-curve table entry generator, top level.
// Depends on gcb_pkg, the two channel interfaces and the gcb_* modules.
//
// Usage: write brightness, contrast, gamma_percent, max_value and table_size
// over the APB-style port (byte addresses 0, 4, 8, 12, 16; pready is always
// high), then send table indexes on index_ch. Each index beat gives one beat
// on entry_ch with the curve value and the out-of-table flag.
// Throughput: one index per clock cycle while the pipeline is not held and
// the sequencer is not busy. Depth: 65 register stages, set by the sixteen
// log2 squaring stages, the 27-stage gamma divider and the sixteen
// root-multiply stages.
// After reset, and after every register write, a sequencer derives slope,
// offset and log2 of the table size; index_ch.ready stays low meanwhile.
// Reset clears every valid bit and restores the default registers.
// When the receiver stalls, one extra result is held in a skid register and
// the whole pipeline then holds; nothing is lost or repeated.
module gamma_contrast_brightness_curve_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    gcb_index_if.sink                      index_ch,
    gcb_entry_if.source                    entry_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gcb_pkg::PADDR_BITS-1:0] paddr,
    input  logic [gcb_pkg::DATA_BITS-1:0]  pwdata,
    output logic [gcb_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready
);

    gcb_pkg::coef_t              coef;
    logic                        busy;
    logic                        adv;
    logic                        fire;
    gcb_pkg::side_t              l_side, d_side, p_side, c_side;
    logic [gcb_pkg::LOG_BITS-1:0] log2i;
    logic [gcb_pkg::DIV_BITS-1:0] expo;
    logic [gcb_pkg::POW_BITS-1:0] pw;
    logic [gcb_pkg::VAL_BITS-1:0] c_value;

    logic                         out_vld_reg, out_vld_next;
    logic [gcb_pkg::VAL_BITS-1:0] out_val_reg, out_val_next;
    logic                         out_err_reg, out_err_next;
    logic                         skid_vld_reg, skid_vld_next;
    logic [gcb_pkg::VAL_BITS-1:0] skid_val_reg, skid_val_next;
    logic                         skid_err_reg, skid_err_next;
    logic                         out_fire;
    logic                         emit;

    assign pready = 1'b1;

    gcb_coef u_coef (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .coef    (coef),
        .busy    (busy)
    );

    // The pipeline moves whenever the skid register is free.
    assign adv            = ~skid_vld_reg;
    assign index_ch.ready = adv & ~busy;
    assign fire           = index_ch.valid & index_ch.ready;

    gcb_log_pipe u_log (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (fire),
        .idx      (index_ch.entry_index),
        .nsize    (coef.nsize),
        .out_side (l_side),
        .log2i    (log2i)
    );

    gcb_div_pipe u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_side  (l_side),
        .log2i    (log2i),
        .log2n    (coef.log2n),
        .gdiv     (coef.gdiv),
        .out_side (d_side),
        .expo     (expo)
    );

    gcb_pow_pipe u_pow (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_side  (d_side),
        .expo     (expo),
        .out_side (p_side),
        .pw       (pw)
    );

    gcb_curve u_curve (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_side  (p_side),
        .pw       (pw),
        .coef     (coef),
        .out_side (c_side),
        .value    (c_value)
    );

    // Output register with a skid register behind it.
    assign out_fire = out_vld_reg & entry_ch.ready;
    assign emit     = adv & c_side.vld;

    always_comb
    begin
        out_vld_next  = out_vld_reg;
        out_val_next  = out_val_reg;
        out_err_next  = out_err_reg;
        skid_vld_next = skid_vld_reg;
        skid_val_next = skid_val_reg;
        skid_err_next = skid_err_reg;
        if (skid_vld_reg)
        begin
            if (out_fire)
            begin
                out_val_next  = skid_val_reg;
                out_err_next  = skid_err_reg;
                skid_vld_next = 1'b0;
            end
        end
        else if (emit)
        begin
            if (!out_vld_reg || out_fire)
            begin
                out_vld_next = 1'b1;
                out_val_next = c_value;
                out_err_next = c_side.err;
            end
            else
            begin
                skid_vld_next = 1'b1;
                skid_val_next = c_value;
                skid_err_next = c_side.err;
            end
        end
        else if (out_fire)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_val_reg  <= out_val_next;
        out_err_reg  <= out_err_next;
        skid_val_reg <= skid_val_next;
        skid_err_reg <= skid_err_next;
    end

    assign entry_ch.valid       = out_vld_reg;
    assign entry_ch.entry_value = out_val_reg;
    assign entry_ch.index_error = out_err_reg;

endmodule

// ===== design/gcb_checker.sv =====
// Port-level checks for the tone-curve generator, bound to the top level.
// Depends on gcb_pkg and gamma_contrast_brightness_curve_unit.
module gcb_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [gcb_pkg::VAL_BITS-1:0] entry_value,
    input logic                         index_error,
    input logic                         pready
);

    // No result beat is offered once reset has been seen at a clock edge.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result offered during reset");

    // A stalled result beat stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat withdrawn while stalled");

    // A stalled result beat keeps its payload.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(entry_value) && $stable(index_error))
        else $error("result payload changed while stalled");

    // An index outside the table always reads as zero.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && index_error |-> entry_value == '0)
        else $error("out-of-table entry with non-zero value");

    // The configuration port never inserts wait states.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind gamma_contrast_brightness_curve_unit gcb_checker u_gcb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (entry_ch.valid),
    .out_ready   (entry_ch.ready),
    .entry_value (entry_ch.entry_value),
    .index_error (entry_ch.index_error),
    .pready      (pready)
);

// ===== sim/gamma_contrast_brightness_curve_unit_tb.sv =====
// Self-checking testbench for the tone-curve table entry generator.
// Depends on gcb_pkg, the two channel interfaces and the top-level RTL.
`timescale 1ns / 100ps

module gamma_contrast_brightness_curve_unit_tb;

    localparam int IDLE_PCT   = 11;
    localparam int DRAIN_WAIT = 70;
    localparam int WDOG_LIMIT = 5000;
    localparam int BLOCK_LEN  = 300;

    // Expected beat on the entry channel.
    typedef struct packed {
        logic        err;
        logic [15:0] value;
    } entry_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [gcb_pkg::PADDR_BITS-1:0] paddr = '0;
    logic [gcb_pkg::DATA_BITS-1:0] pwdata = '0;
    logic [gcb_pkg::DATA_BITS-1:0] prdata;
    logic pready;

    gcb_index_if idx_ch ();
    gcb_entry_if ent_ch ();

    gamma_contrast_brightness_curve_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .index_ch (idx_ch.sink),
        .entry_ch (ent_ch.source),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow copy of the configuration registers.
    logic [7:0]  cfg_bright = 8'd0;
    logic [7:0]  cfg_contr  = 8'd0;
    logic [9:0]  cfg_gamma  = 10'd100;
    logic [15:0] cfg_maxv   = 16'd255;
    logic [12:0] cfg_tsize  = 13'd256;

    logic [11:0] index_q[$];
    entry_t      entry_exp_q[$];
    longint unsigned half_roots[16];

    int  errors = 0;
    int  quiet_cycles = 0;
    bit  calm = 1'b0;
    bit  block_req = 1'b0;
    int  block_left = 0;
    logic in_beat = 1'b0;

    always #6 clk = ~clk;

    initial
    begin
        idx_ch.valid = 1'b0;
        idx_ch.entry_index = '0;
        ent_ch.ready = 1'b0;
    end

    // Bitwise integer square root used to build the 2^-2^-k constants.
    function automatic longint unsigned sqrt_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Q16.16 base-two logarithm by repeated squaring of the mantissa.
    function automatic longint unsigned log2_fix(input longint unsigned v);
        int unsigned     msb;
        longint unsigned mant;
        longint unsigned frac;
        msb = 0;
        frac = 0;
        for (int i = 1; i < 13; i++)
            if (v[i])
                msb = i;
        mant = v << (31 - msb);
        for (int k = 0; k < 16; k++)
        begin
            mant = (mant * mant) >> 31;
            frac = frac << 1;
            if (mant >= 64'h1_0000_0000)
            begin
                frac = frac | 1;
                mant = mant >> 1;
            end
        end
        return (longint'(msb) << 16) | frac;
    endfunction

    // Curve value for one index under the current register settings.
    function automatic entry_t curve_entry(input logic [11:0] idx);
        entry_t          r;
        longint unsigned n;
        longint unsigned mv;
        longint unsigned g;
        longint unsigned p;
        longint unsigned m;
        longint unsigned whole;
        longint          c;
        longint          b;
        longint          x;
        longint          half;
        longint          slope;
        longint          y;
        n = cfg_tsize;
        mv = cfg_maxv;
        g = (cfg_gamma == 0) ? 1 : cfg_gamma;
        p = 0;
        if (n > gcb_pkg::MAX_TABLE_SIZE)
            n = gcb_pkg::MAX_TABLE_SIZE;
        if (idx >= n)
        begin
            r.err = 1'b1;
            r.value = 16'd0;
            return r;
        end
        if (idx != 0)
        begin
            m = ((log2_fix(n) - log2_fix(idx)) * 100) / g;
            whole = m >> 16;
            p = 64'h1_0000_0000;
            for (int j = 0; j < 16; j++)
                if (m[15 - j])
                    p = (p * half_roots[j]) >> 32;
            p = (whole >= 32) ? 0 : (p >> whole);
        end
        c = longint'($signed(cfg_contr));
        if (c < -100)
            c = -100;
        if (c > 99)
            c = 99;
        b = longint'($signed(cfg_bright));
        x = longint'((p * mv) >> 16);
        half = longint'(mv << 15);
        slope = (longint'(200) * 65536) / (100 - c) - 65536;
        y = ((slope * (x - half)) >>> 16) + half;
        y = y + (b * longint'(mv) * 65536) / 100;
        y = y + 32768;
        r.err = 1'b0;
        if (y > longint'(mv << 16))
            r.value = mv[15:0];
        else if (y < 0)
            r.value = 16'd0;
        else
            r.value = y[31:16];
        return r;
    endfunction

    // Index driver: offers the next queued index, idling at random.
    always @(negedge clk)
    begin
        if (rst_n && (!idx_ch.valid || in_beat))
        begin
            if (index_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                idx_ch.entry_index <= index_q.pop_front();
                idx_ch.valid <= 1'b1;
            end
            else
            begin
                idx_ch.valid <= 1'b0;
            end
        end
    end

    // Entry receiver: random stalls plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            ent_ch.ready <= 1'b0;
        end
        else if (block_req && block_left == 0)
        begin
            block_req <= 1'b0;
            block_left <= BLOCK_LEN;
            ent_ch.ready <= 1'b0;
        end
        else if (block_left > 0)
        begin
            block_left <= block_left - 1;
            ent_ch.ready <= (block_left == 1);
        end
        else
        begin
            ent_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor: predicts on index beats and checks entry beats.
    always @(posedge clk)
    begin
        entry_t want;
        in_beat <= idx_ch.valid && idx_ch.ready;
        if (rst_n)
        begin
            if (idx_ch.valid && idx_ch.ready)
                entry_exp_q.push_back(curve_entry(idx_ch.entry_index));
            if (ent_ch.valid && ent_ch.ready)
            begin
                if (entry_exp_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected entry beat: value %0d err %0b",
                                 ent_ch.entry_value, ent_ch.index_error);
                end
                else
                begin
                    want = entry_exp_q.pop_front();
                    if (want.value !== ent_ch.entry_value
                        || want.err !== ent_ch.index_error)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("entry mismatch: expected %0d/%0b, got %0d/%0b",
                                     want.value, want.err,
                                     ent_ch.entry_value, ent_ch.index_error);
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which no beat and no register write happens.
    always @(posedge clk)
    begin
        if ((idx_ch.valid && idx_ch.ready) || (ent_ch.valid && ent_ch.ready)
            || psel || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT)
        begin
            $display("[gamma_contrast_brightness_curve_unit] ERROR");
            $finish;
        end
    end

    // Register write: setup cycle then access cycle.
    task automatic reg_write(input logic [2:0] reg_idx, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {reg_idx, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        while (index_q.size() != 0 || idx_ch.valid || entry_exp_q.size() != 0)
            @(posedge clk);
    endtask

    // Waits for idle, then programs all five registers.
    task automatic set_curve(input logic [7:0] bri, input logic [7:0] con,
                             input logic [9:0] gam, input logic [15:0] mv,
                             input logic [12:0] ts);
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        reg_write(gcb_pkg::REG_BRIGHTNESS, {24'd0, bri});
        reg_write(gcb_pkg::REG_CONTRAST, {24'd0, con});
        reg_write(gcb_pkg::REG_GAMMA, {22'd0, gam});
        reg_write(gcb_pkg::REG_MAX_VALUE, {16'd0, mv});
        reg_write(gcb_pkg::REG_TABLE_SIZE, {19'd0, ts});
        cfg_bright = bri;
        cfg_contr = con;
        cfg_gamma = gam;
        cfg_maxv = mv;
        cfg_tsize = ts;
    endtask

    // Queues random indexes, mostly inside the table in use.
    task automatic queue_random(input int count);
        int lim;
        lim = (cfg_tsize == 0) ? 1
            : ((cfg_tsize > gcb_pkg::MAX_TABLE_SIZE) ? gcb_pkg::MAX_TABLE_SIZE
                                                     : cfg_tsize);
        for (int i = 0; i < count; i++)
            if ($urandom_range(99) < 75)
                index_q.push_back(12'($urandom_range(lim - 1)));
            else
                index_q.push_back(12'($urandom));
    endtask

    initial
    begin
        half_roots[0] = sqrt_floor(64'h8000_0000_0000_0000);
        for (int k = 1; k < 16; k++)
            half_roots[k] = sqrt_floor(half_roots[k - 1] << 32);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed indexes at the reset settings.
        index_q.push_back(12'd0);
        index_q.push_back(12'd1);
        index_q.push_back(12'd2);
        index_q.push_back(12'd127);
        index_q.push_back(12'd128);
        index_q.push_back(12'd255);
        index_q.push_back(12'd256);
        index_q.push_back(12'd4095);
        index_q.push_back(12'hAAA);
        index_q.push_back(12'h555);

        // Extreme settings, including the out-of-range register cases.
        set_curve(8'(-100), 8'(-100), 10'd1, 16'd65535, 13'd4096);
        index_q.push_back(12'd0);
        index_q.push_back(12'd1);
        index_q.push_back(12'd4095);
        set_curve(8'd100, 8'd99, 10'd999, 16'd1, 13'd2);
        index_q.push_back(12'd0);
        index_q.push_back(12'd1);
        index_q.push_back(12'd2);
        set_curve(8'h7F, 8'h80, 10'd0, 16'd0, 13'd0);
        index_q.push_back(12'd0);
        index_q.push_back(12'd4095);
        set_curve(8'h80, 8'h7F, 10'h3FF, 16'hFFFF, 13'h1FFF);
        index_q.push_back(12'd0);
        index_q.push_back(12'd1);
        index_q.push_back(12'd4095);

        // Long receiver hold-off while the sender keeps offering.
        queue_random(150);
        block_req = 1'b1;

        // A burst with no idling on either side.
        set_curve(8'd0, 8'd0, 10'd100, 16'd255, 13'd256);
        calm = 1'b1;
        queue_random(150);
        wait_drained();
        calm = 1'b0;

        // Random settings; sender pauses mid-phase once.
        for (int ph = 0; ph < 10; ph++)
        begin
            set_curve(8'($urandom), 8'($urandom), 10'($urandom), 16'($urandom),
                      ($urandom_range(3) == 0) ? 13'($urandom)
                                               : 13'($urandom_range(4096, 2)));
            queue_random(60);
            if (ph == 2)
                wait_drained();
            queue_random(65);
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (entry_exp_q.size() != 0)
            errors++;
        if (errors == 0)
            $display("[gamma_contrast_brightness_curve_unit] OK");
        else
            $display("[gamma_contrast_brightness_curve_unit] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/gcb_pkg.sv
design/gcb_index_if.sv
design/gcb_entry_if.sv
design/gcb_coef.sv
design/gcb_log_pipe.sv
design/gcb_div_pipe.sv
design/gcb_pow_pipe.sv
design/gcb_curve.sv
design/gamma_contrast_brightness_curve_unit.sv
design/gcb_checker.sv
sim/gamma_contrast_brightness_curve_unit_tb.sv
